### hdl/mlfd_pkg.sv
// Shared types and constants for the magic/length frame deframer.
`timescale 1ns / 1ps

package mlfd_pkg;

    // Width of the id/payload byte counter.
    localparam int LENGTH_BITS = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAGIC_WORD   = 2'd0,
        REG_MAX_ID_LEN   = 2'd1,
        REG_MAX_PAY_LEN  = 2'd2
    } reg_index_t;

    localparam logic [31:0] MAGIC_WORD_RST  = 32'h0000_0000;
    localparam logic [7:0]  MAX_ID_LEN_RST  = 8'hFF;
    localparam logic [15:0] MAX_PAY_LEN_RST = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_IDLEN   = 3'd2,
        PH_ID      = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CLOSED  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        K_HEADER   = 3'd0,
        K_ID       = 3'd1,
        K_PAYLOAD  = 3'd2,
        K_BADMAGIC = 3'd3,
        K_BADID    = 3'd4,
        K_TOOLONG  = 3'd5,
        K_CLOSED   = 3'd6
    } kind_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  max_id_length;
        logic [15:0] max_payload_length;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic        last;
    } res_t;

endpackage

### hdl/mlfd_cfg_regs.sv
// Configuration register file for the deframer.
`timescale 1ns / 1ps

module mlfd_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mlfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mlfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mlfd_pkg::cfg_t                    cfg
);

    mlfd_pkg::cfg_t cfg_reg;
    mlfd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                mlfd_pkg::REG_MAGIC_WORD:  cfg_next.magic_word         = cfg_data[31:0];
                mlfd_pkg::REG_MAX_ID_LEN:  cfg_next.max_id_length      = cfg_data[7:0];
                mlfd_pkg::REG_MAX_PAY_LEN: cfg_next.max_payload_length = cfg_data[15:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word         <= mlfd_pkg::MAGIC_WORD_RST;
            cfg_reg.max_id_length      <= mlfd_pkg::MAX_ID_LEN_RST;
            cfg_reg.max_payload_length <= mlfd_pkg::MAX_PAY_LEN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/mlfd_parser.sv
// Frame phase tracker: classifies each accepted byte and advances the frame state.
`timescale 1ns / 1ps

module mlfd_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic [7:0]      in_byte,
    input  mlfd_pkg::cfg_t  cfg,
    output mlfd_pkg::res_t  res
);

    localparam int LB = mlfd_pkg::LENGTH_BITS;

    mlfd_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       hdr_idx_reg, hdr_idx_next;
    logic [23:0]      asm_reg, asm_next;
    logic [LB-1:0]    rem_reg, rem_next;

    logic [31:0] full_word;
    logic        word_done;
    logic        rem_last;
    logic        bad_id;
    logic        too_long;
    logic        bad_magic;

    assign full_word = {asm_reg, in_byte};
    assign word_done = (hdr_idx_reg == 2'd3);
    assign rem_last  = (rem_reg <= LB'(1));
    assign bad_id    = (in_byte == 8'd0) || (in_byte > cfg.max_id_length);
    assign bad_magic = (full_word != cfg.magic_word);
    // Too long for the register, or not representable in the counter.
    assign too_long  = (full_word > 32'(cfg.max_payload_length))
                    || ((full_word >> LB) != 32'd0);

    // Next state
    always_comb begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        asm_next     = asm_reg;
        rem_next     = rem_reg;
        if (in_fire) begin
            if ((phase_reg == mlfd_pkg::PH_MAGIC) || (phase_reg == mlfd_pkg::PH_LEN)) begin
                if (word_done) begin
                    hdr_idx_next = 2'd0;
                    asm_next     = 24'd0;
                end else begin
                    hdr_idx_next = hdr_idx_reg + 2'd1;
                    asm_next     = {asm_reg[15:0], in_byte};
                end
            end
            case (phase_reg)
                mlfd_pkg::PH_MAGIC: begin
                    if (word_done) begin
                        phase_next = bad_magic ? mlfd_pkg::PH_CLOSED : mlfd_pkg::PH_VERSION;
                    end
                end
                mlfd_pkg::PH_VERSION: begin
                    phase_next = mlfd_pkg::PH_IDLEN;
                end
                mlfd_pkg::PH_IDLEN: begin
                    if (bad_id) begin
                        phase_next = mlfd_pkg::PH_CLOSED;
                    end else begin
                        rem_next   = LB'(in_byte);
                        phase_next = mlfd_pkg::PH_ID;
                    end
                end
                mlfd_pkg::PH_ID: begin
                    if (rem_last) begin
                        rem_next   = '0;
                        phase_next = mlfd_pkg::PH_LEN;
                    end else begin
                        rem_next = rem_reg - LB'(1);
                    end
                end
                mlfd_pkg::PH_LEN: begin
                    if (word_done) begin
                        if (too_long) begin
                            phase_next = mlfd_pkg::PH_CLOSED;
                        end else if (full_word == 32'd0) begin
                            phase_next = mlfd_pkg::PH_MAGIC;
                        end else begin
                            rem_next   = full_word[LB-1:0];
                            phase_next = mlfd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                mlfd_pkg::PH_PAYLOAD: begin
                    if (rem_last) begin
                        rem_next   = '0;
                        phase_next = mlfd_pkg::PH_MAGIC;
                    end else begin
                        rem_next = rem_reg - LB'(1);
                    end
                end
                default: begin
                    phase_next = mlfd_pkg::PH_CLOSED;
                end
            endcase
        end
    end

    // Result for the byte currently presented
    always_comb begin
        res.value = in_byte;
        res.kind  = mlfd_pkg::K_HEADER;
        res.last  = 1'b0;
        case (phase_reg)
            mlfd_pkg::PH_MAGIC: begin
                if (word_done && bad_magic) res.kind = mlfd_pkg::K_BADMAGIC;
            end
            mlfd_pkg::PH_VERSION: ;
            mlfd_pkg::PH_IDLEN: begin
                if (bad_id) res.kind = mlfd_pkg::K_BADID;
            end
            mlfd_pkg::PH_ID: begin
                res.kind = mlfd_pkg::K_ID;
                res.last = rem_last;
            end
            mlfd_pkg::PH_LEN: begin
                if (word_done && too_long) res.kind = mlfd_pkg::K_TOOLONG;
            end
            mlfd_pkg::PH_PAYLOAD: begin
                res.kind = mlfd_pkg::K_PAYLOAD;
                res.last = rem_last;
            end
            default: begin
                res.kind = mlfd_pkg::K_CLOSED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= mlfd_pkg::PH_MAGIC;
            hdr_idx_reg <= 2'd0;
            asm_reg     <= 24'd0;
            rem_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            asm_reg     <= asm_next;
            rem_reg     <= rem_next;
        end
    end

`ifndef SYNTH
    // Closed is sticky until reset.
    a_closed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == mlfd_pkg::PH_CLOSED) |=> (phase_reg == mlfd_pkg::PH_CLOSED))
        else $error("closed state left without reset");

    // Any reported error must close the stream.
    a_error_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && ((res.kind == mlfd_pkg::K_BADMAGIC) || (res.kind == mlfd_pkg::K_BADID)
                     || (res.kind == mlfd_pkg::K_TOOLONG)))
        |=> (phase_reg == mlfd_pkg::PH_CLOSED))
        else $error("error reported without closing");

    // Counted fields never sit with a zero count.
    a_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == mlfd_pkg::PH_ID) || (phase_reg == mlfd_pkg::PH_PAYLOAD))
        |-> (rem_reg != '0))
        else $error("id/payload phase with zero bytes remaining");

    // Word assembly index is clear outside the 4-byte header words.
    a_idx_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !((phase_reg == mlfd_pkg::PH_MAGIC) || (phase_reg == mlfd_pkg::PH_LEN))
        |-> (hdr_idx_reg == 2'd0))
        else $error("header byte index left non-zero");
`endif

endmodule

### hdl/mlfd_out_buf.sv
// Output register with a skid stage so the input side never waits on m_tready directly.
`timescale 1ns / 1ps

module mlfd_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  mlfd_pkg::res_t  in_res,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output mlfd_pkg::res_t  out_res
);

    mlfd_pkg::res_t main_reg, main_next;
    mlfd_pkg::res_t skid_reg, skid_next;
    logic           main_valid_reg, main_valid_next;
    logic           skid_valid_reg, skid_valid_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_ready || !main_valid_reg) begin
            // Main slot drains: refill from skid first, then from the input.
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else if (in_fire) begin
                main_next       = in_res;
                main_valid_next = 1'b1;
            end else begin
                main_valid_next = 1'b0;
            end
        end else if (in_fire) begin
            // Main slot stalled: park the beat.
            skid_next       = in_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

endmodule

### hdl/magic_length_frame_deframer_top.sv
// An accepted byte's tag is registered in the main register, or in the skid while m_* stalls.
// One byte per cycle unless the skid is full; phase update and compares feed the result register.
// A two-entry output stage (main register plus skid) keeps s_tready independent of m_tready.
// Reset (aresetn low, synchronous): frame state returns to expecting the magic word, output
// stage empties, and the configuration registers return to magic 0, max id 255, max payload 65535.
`timescale 1ns / 1ps

module magic_length_frame_deframer_top (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Received byte stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte

    // Tagged byte stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] value
    output logic [2:0]                        m_tuser,   // [2:0] kind
    output logic                              m_tlast,   // last id / payload byte

    // Configuration writes: index 0 magic_word, 1 max_id_length, 2 max_payload_length
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mlfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mlfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mlfd_pkg::cfg_t cfg;
    mlfd_pkg::res_t parse_res;
    mlfd_pkg::res_t out_res;
    logic           in_fire;

    // A beat moves when the skid slot is free.
    assign in_fire = s_tvalid && s_tready;

    mlfd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Classify the incoming byte and advance the frame phase on each accepted beat.
    mlfd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .cfg     (cfg),
        .res     (parse_res)
    );

    // Hold results until the downstream side takes them.
    mlfd_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_res    (parse_res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.value;
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

### tb/sv/tb_magic_length_frame_deframer_top.sv
// Self-checking testbench for the magic/length frame deframer: framed byte streams in, tags checked.
`timescale 1ns / 1ps

module tb_magic_length_frame_deframer_top;
    import mlfd_pkg::*;

    // Index past the register list; a write there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no beat anywhere before giving up
    localparam int CHOKE_CYCLES = 300;    // one long receiver hold-off
    localparam int BYTE_GOAL    = 1450;   // stop opening new settings past this many bytes

    // Tracks the frame walk byte by byte and holds the tags still owed by the block.
    class frame_walker;
        logic [31:0]            magic;
        logic [7:0]             max_id;
        logic [15:0]            max_pay;
        phase_t                 step_phase;
        logic [1:0]             word_pos;
        logic [23:0]            word_acc;
        logic [LENGTH_BITS-1:0] left;
        res_t                   pending_tags[$];
        int unsigned            errors;

        function new();
            magic      = MAGIC_WORD_RST;
            max_id     = MAX_ID_LEN_RST;
            max_pay    = MAX_PAY_LEN_RST;
            step_phase = PH_MAGIC;
            word_pos   = '0;
            word_acc   = '0;
            left       = '0;
            errors     = 0;
        endfunction

        function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
            case (idx)
                REG_MAGIC_WORD:  magic   = val;
                REG_MAX_ID_LEN:  max_id  = val[7:0];
                REG_MAX_PAY_LEN: max_pay = val[15:0];
                default: ;
            endcase
        endfunction

        // Shift one byte into the big-endian word; true once the fourth byte lands.
        function bit word_done(input logic [7:0] b, output logic [31:0] full);
            full = {word_acc, b};
            if (word_pos == 2'd3) begin
                word_acc = '0;
                word_pos = '0;
                return 1'b1;
            end
            word_acc = {word_acc[15:0], b};
            word_pos++;
            return 1'b0;
        endfunction

        function void take_byte(input logic [7:0] b);
            res_t        tag;
            logic [31:0] full;
            tag.kind  = K_HEADER;
            tag.value = b;
            tag.last  = 1'b0;
            case (step_phase)
                PH_MAGIC: begin
                    if (word_done(b, full)) begin
                        if (full != magic) begin
                            tag.kind   = K_BADMAGIC;
                            step_phase = PH_CLOSED;
                        end else begin
                            step_phase = PH_VERSION;
                        end
                    end
                end
                PH_VERSION: step_phase = PH_IDLEN;
                PH_IDLEN: begin
                    if (b == 8'd0 || b > max_id) begin
                        tag.kind   = K_BADID;
                        step_phase = PH_CLOSED;
                    end else begin
                        left       = LENGTH_BITS'(b);
                        step_phase = PH_ID;
                    end
                end
                PH_ID: begin
                    tag.kind = K_ID;
                    if (left <= 1) begin
                        tag.last   = 1'b1;
                        left       = '0;
                        step_phase = PH_LEN;
                    end else begin
                        left--;
                    end
                end
                PH_LEN: begin
                    if (word_done(b, full)) begin
                        if (full > max_pay || (full >> LENGTH_BITS) != 0) begin
                            tag.kind   = K_TOOLONG;
                            step_phase = PH_CLOSED;
                        end else if (full == 0) begin
                            step_phase = PH_MAGIC;
                        end else begin
                            left       = full[LENGTH_BITS-1:0];
                            step_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    tag.kind = K_PAYLOAD;
                    if (left <= 1) begin
                        tag.last   = 1'b1;
                        left       = '0;
                        step_phase = PH_MAGIC;
                    end else begin
                        left--;
                    end
                end
                default: begin
                    tag.kind   = K_CLOSED;
                    step_phase = PH_CLOSED;
                end
            endcase
            pending_tags.push_back(tag);
        endfunction

        function void match_tag(input logic [2:0] k, input logic [7:0] v, input logic l);
            res_t want;
            if (pending_tags.size() == 0) begin
                $display("%0t: unexpected beat kind %0d value 0x%02h last %0b", $time, k, v, l);
                errors++;
                return;
            end
            want = pending_tags.pop_front();
            if (k !== want.kind) begin
                $display("%0t: kind mismatch: expected %0d, actual %0d", $time, want.kind, k);
                errors++;
            end
            if (v !== want.value) begin
                $display("%0t: value mismatch: expected 0x%02h, actual 0x%02h",
                         $time, want.value, v);
                errors++;
            end
            if (l !== want.last) begin
                $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, l);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;
    logic [2:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    frame_walker walker = new();

    int unsigned bytes_sent   = 0;
    int unsigned quiet_cycles = 0;
    bit          src_gaps     = 1'b1;   // sender may insert idle cycles
    bit          sink_gaps    = 1'b1;   // receiver may drop m_tready at random
    bit          choke_req    = 1'b0;   // ask the receiver for one long hold-off

    magic_length_frame_deframer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Sample both channels at the rising edge: predict on every accepted input
    // beat, check every accepted result beat, and track how long nothing moved.
    always @(posedge aclk) begin
        if (s_tvalid && s_tready)
            walker.take_byte(s_tdata);
        if (m_tvalid && m_tready)
            walker.match_tag(m_tuser, m_tdata, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Abort when the block stops moving beats altogether.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: drop m_tready at random, or hold it low for one long stretch on request.
    initial begin
        int unsigned hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (choke_req) begin
                hold      = CHOKE_CYCLES;
                choke_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !sink_gaps || ($urandom_range(99) >= 36);
            end
        end
    end

    // Offer one byte, with random idle cycles ahead of it; return once it is taken.
    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while (src_gaps && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Send a 32-bit word most significant byte first.
    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(w[8*i +: 8]);
    endtask

    // Magic word, random version byte, id length byte, then id_bytes random id bytes.
    task automatic send_prefix(input logic [7:0] id_len, input int unsigned id_bytes);
        send_word(walker.magic);
        send_byte(8'($urandom));
        send_byte(id_len);
        repeat (id_bytes) send_byte(8'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        walker.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering bytes and wait until every owed tag has come back.
    task automatic drain_stream();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (walker.pending_tags.size() != 0) @(negedge aclk);
    endtask

    initial begin
        logic [31:0] magic_pick;
        logic [7:0]  id_pick;
        logic [15:0] pay_pick;
        int unsigned id_len;
        int unsigned pay_len;
        int unsigned cap;
        int unsigned pick;
        int unsigned phase_end;
        bit          first_frame;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAGIC_WORD;
        cfg_data  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed frames on reset settings (magic 0): a zero-length frame that
        // loops straight back to the magic word, then a short full frame with
        // all-zero and all-one bytes in its id and its payload.
        send_word(32'h0000_0000);
        send_byte(8'hFF);
        send_byte(8'd1);
        send_byte(8'h00);
        send_word(32'd0);
        send_word(32'h0000_0000);
        send_byte(8'h00);
        send_byte(8'd2);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_word(32'd2);
        send_byte(8'hFF);
        send_byte(8'h00);
        drain_stream();

        // Well-formed frames under a new register setting per pass. Only frame
        // boundaries are crossed between passes, since any framing error closes
        // the block for good.
        for (int p = 0; bytes_sent < BYTE_GOAL; p++) begin
            case (p)
                0: begin
                    // Low extremes: all-ones magic, one id byte, no payload allowed.
                    magic_pick = 32'hFFFF_FFFF;
                    id_pick    = 8'd1;
                    pay_pick   = 16'd0;
                end
                1: begin
                    magic_pick = $urandom;
                    id_pick    = 8'd255;
                    pay_pick   = 16'hFFFF;
                end
                2: begin
                    magic_pick = $urandom;
                    id_pick    = 8'($urandom_range(255, 1));
                    pay_pick   = 16'($urandom_range(64, 1));
                end
                default: begin
                    magic_pick = ($urandom_range(5) == 0) ? 32'h0000_0000 : $urandom;
                    id_pick    = 8'($urandom_range(255, 1));
                    pay_pick   = ($urandom_range(3) == 0) ? 16'hFFFF
                                                          : 16'($urandom_range(40));
                end
            endcase
            // Junk in the upper data bits must be dropped by the register.
            write_reg(REG_MAGIC_WORD, magic_pick);
            write_reg(REG_MAX_ID_LEN, ($urandom << 8) | id_pick);
            write_reg(REG_MAX_PAY_LEN, ($urandom << 16) | pay_pick);
            if (p == 1) begin
                write_reg(REG_SPARE, $urandom);
                choke_req = 1'b1;   // fill the output stage and stall the input
            end
            // Run one pass with no idling on either side.
            src_gaps  = (p != 2);
            sink_gaps = (p != 2);

            phase_end   = bytes_sent + 240;
            first_frame = 1'b1;
            while (bytes_sent < phase_end) begin
                // Open each pass with the longest id allowed, then mostly short ids.
                if (first_frame)
                    id_len = walker.max_id;
                else if ($urandom_range(7) == 0)
                    id_len = $urandom_range(walker.max_id, 1);
                else
                    id_len = $urandom_range((walker.max_id < 6) ? walker.max_id : 6, 1);
                cap  = (walker.max_pay < 300) ? walker.max_pay : 300;
                pick = $urandom_range(9);
                if (pick == 0)
                    pay_len = 0;
                else if (pick == 1)
                    pay_len = $urandom_range(cap);
                else if (pick == 2)
                    pay_len = cap;
                else
                    pay_len = $urandom_range((cap < 20) ? cap : 20);
                send_prefix(8'(id_len), id_len);
                send_word(pay_len);
                repeat (pay_len) send_byte(8'($urandom));
                first_frame = 1'b0;
            end
            drain_stream();
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;

        // Break one frame in one of the ways the block reports, then feed noise
        // that must all be discarded while closed.
        case ($urandom_range(3))
            0: send_word(walker.magic ^ (32'd1 << $urandom_range(31)));
            1: send_prefix(8'd0, 0);
            2: begin
                // A zero limit rejects every id length.
                write_reg(REG_MAX_ID_LEN, $urandom_range(1) ? 32'd0 : $urandom_range(254));
                send_prefix(8'($urandom_range(255, walker.max_id + 1)), 0);
            end
            default: begin
                write_reg(REG_MAX_PAY_LEN, $urandom_range(65534));
                send_prefix(8'd1, 1);
                // Either one past the limit or too wide for the byte counter.
                send_word($urandom_range(1) ? walker.max_pay + 32'd1
                                            : ($urandom | 32'h0001_0000));
            end
        endcase
        repeat (30) send_byte(8'($urandom));
        drain_stream();

        // Give a stray extra beat a chance to show up before the verdict.
        repeat (4) @(negedge aclk);
        if (walker.errors == 0 && walker.pending_tags.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
